>>> rtl/epv_pkg.sv
package epv_pkg;

    localparam int unsigned DATA_WIDTH      = 32;
    localparam int unsigned DIST_WIDTH      = 48;
    localparam int unsigned MIN_WIDTH       = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned STEP_CNT_WIDTH  = $clog2(DATA_WIDTH);

    localparam logic [MIN_WIDTH-1:0]  MIN_PERIOD_RESET  = 16'd100;
    localparam logic [DATA_WIDTH-1:0] SPEED_CONST_RESET = 32'd2613806;
    localparam logic [DATA_WIDTH-1:0] RPM_CONST_RESET   = 32'd768000000;
    localparam logic [DATA_WIDTH-1:0] STEP_DIST_RESET   = 32'd0;
    localparam logic [DATA_WIDTH-1:0] SPEED_MAX         = 32'h7FFF_FFFF;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MIN_PERIOD  = 2'd0,
        CFG_SPEED_CONST = 2'd1,
        CFG_RPM_CONST   = 2'd2,
        CFG_STEP_DIST   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_SPD,
        ST_DIV_RPM,
        ST_DONE
    } epv_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/epv_div.sv
module epv_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [epv_pkg::DATA_WIDTH-1:0]  dividend,
    input  logic [epv_pkg::DATA_WIDTH-1:0]  divisor,
    output logic [epv_pkg::DATA_WIDTH-1:0]  quotient,
    output epv_pkg::div_status_t            status
);
    import epv_pkg::*;

    localparam logic [STEP_CNT_WIDTH-1:0] LAST_STEP = STEP_CNT_WIDTH'(DATA_WIDTH - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [STEP_CNT_WIDTH-1:0] count_reg;
    logic [DATA_WIDTH-1:0]     rem_reg;
    logic [DATA_WIDTH-1:0]     quot_reg;
    logic [DATA_WIDTH-1:0]     div_reg;

    logic [DATA_WIDTH:0]       shifted;
    logic [DATA_WIDTH:0]       diff;
    logic                      borrow;

    assign shifted = {rem_reg, quot_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign borrow  = diff[DATA_WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                count_reg <= count_reg + STEP_CNT_WIDTH'(1);
                if (count_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= borrow ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
            quot_reg <= {quot_reg[DATA_WIDTH-2:0], ~borrow};
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider not busy after start");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && count_reg == LAST_STEP) |=> (done_reg && !busy_reg))
        else $error("divider failed to finish on last step");
`endif

endmodule

>>> rtl/encoder_period_velocity.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------------
// input    | s_valid / s_ready  | s_channel, s_capture, s_direction, s_now_ms
// result   | m_valid / m_ready  | m_out_channel, m_period, m_speed_q8, m_rpm_q8,
//          |                    | m_distance_q16, m_edge_count, m_active,
//          |                    | m_edge_time_ms
// config   | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A period that does not exceed min_period skips both divisions and goes to the final state.
// A period above min_period runs two 32-bit divisions on one shared restoring divider, one
// quotient bit per cycle, speed first and then rpm, before m_valid is raised.
// s_ready is high only while the sequencer is idle, from the cycle after a result is loaded;
// a held result register keeps the next transaction waiting in the final state.
// Synchronous active-low reset restores the configuration defaults and clears both channels.
module encoder_period_velocity #(
    parameter int unsigned CAPTURE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_channel,
    input  logic [epv_pkg::DATA_WIDTH-1:0]       s_capture,
    input  logic signed [1:0]                    s_direction,
    input  logic [epv_pkg::DATA_WIDTH-1:0]       s_now_ms,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_out_channel,
    output logic [epv_pkg::DATA_WIDTH-1:0]       m_period,
    output logic signed [epv_pkg::DATA_WIDTH-1:0] m_speed_q8,
    output logic [epv_pkg::DATA_WIDTH-1:0]       m_rpm_q8,
    output logic signed [epv_pkg::DIST_WIDTH-1:0] m_distance_q16,
    output logic [epv_pkg::DATA_WIDTH-1:0]       m_edge_count,
    output logic                                 m_active,
    output logic [epv_pkg::DATA_WIDTH-1:0]       m_edge_time_ms,

    input  logic                                 cfg_wr_en,
    input  logic [epv_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [epv_pkg::DATA_WIDTH-1:0]       cfg_wr_data
);
    import epv_pkg::*;

    logic [MIN_WIDTH-1:0]  min_period_reg;
    logic [DATA_WIDTH-1:0] speed_const_reg;
    logic [DATA_WIDTH-1:0] rpm_const_reg;
    logic [DATA_WIDTH-1:0] step_dist_reg;

    logic [CAPTURE_WIDTH-1:0] last_capture_reg [2];
    logic [DATA_WIDTH-1:0]    edge_period_reg  [2];
    logic [DATA_WIDTH-1:0]    speed_reg        [2];
    logic [DATA_WIDTH-1:0]    rpm_reg          [2];
    logic [DIST_WIDTH-1:0]    travelled_reg    [2];
    logic [DATA_WIDTH-1:0]    edges_reg        [2];
    logic                     active_reg       [2];
    logic [DATA_WIDTH-1:0]    edge_time_reg    [2];

    epv_state_t               state_reg, state_next;
    logic                     ch_reg;
    logic [CAPTURE_WIDTH-1:0] cap_reg;
    logic [1:0]               dir_reg;
    logic [DATA_WIDTH-1:0]    now_reg;
    logic [DATA_WIDTH-1:0]    per_reg;

    logic                     m_valid_reg;
    logic                     out_ch_reg;
    logic [DATA_WIDTH-1:0]    out_period_reg;
    logic [DATA_WIDTH-1:0]    out_speed_reg;
    logic [DATA_WIDTH-1:0]    out_rpm_reg;
    logic [DIST_WIDTH-1:0]    out_dist_reg;
    logic [DATA_WIDTH-1:0]    out_edges_reg;
    logic                     out_active_reg;
    logic [DATA_WIDTH-1:0]    out_time_reg;

    logic [CAPTURE_WIDTH-1:0] per_cw;
    logic [DATA_WIDTH-1:0]    per_ext;
    logic                     per_ok;
    logic                     dir_neg;
    logic                     dir_pos;
    logic [DATA_WIDTH-1:0]    speed_mag;
    logic [DIST_WIDTH-1:0]    step_ext;

    logic                     div_start;
    logic [DATA_WIDTH-1:0]    div_dividend;
    logic [DATA_WIDTH-1:0]    div_divisor;
    logic [DATA_WIDTH-1:0]    div_quot;
    div_status_t              div_status;
    logic                     load_out;

    assign per_cw    = cap_reg - last_capture_reg[ch_reg];
    assign per_ext   = DATA_WIDTH'(per_cw);
    assign per_ok    = per_ext > DATA_WIDTH'(min_period_reg);
    assign dir_neg   = dir_reg[1];
    assign dir_pos   = (dir_reg == 2'b01);
    assign speed_mag = (div_quot > SPEED_MAX) ? SPEED_MAX : div_quot;
    assign step_ext  = DIST_WIDTH'(step_dist_reg);

    epv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg  <= MIN_PERIOD_RESET;
            speed_const_reg <= SPEED_CONST_RESET;
            rpm_const_reg   <= RPM_CONST_RESET;
            step_dist_reg   <= STEP_DIST_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_PERIOD:  min_period_reg  <= cfg_wr_data[MIN_WIDTH-1:0];
                CFG_SPEED_CONST: speed_const_reg <= cfg_wr_data;
                CFG_RPM_CONST:   rpm_const_reg   <= cfg_wr_data;
                CFG_STEP_DIST:   step_dist_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = speed_const_reg;
        div_divisor  = per_reg;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (per_ok) begin
                    div_start   = 1'b1;
                    div_divisor = per_ext;
                    state_next  = ST_DIV_SPD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_SPD: begin
                if (div_status.done) begin
                    div_start    = 1'b1;
                    div_dividend = rpm_const_reg;
                    state_next   = ST_DIV_RPM;
                end
            end
            ST_DIV_RPM: begin
                if (div_status.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg  <= s_channel;
            cap_reg <= s_capture[CAPTURE_WIDTH-1:0];
            dir_reg <= s_direction;
            now_reg <= s_now_ms;
        end
        if (state_reg == ST_LOAD) begin
            per_reg <= per_ext;
        end
    end

    // Per-channel state: update on load, then latch division results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 2; c++) begin
                last_capture_reg[c] <= '0;
                edge_period_reg[c]  <= '0;
                speed_reg[c]        <= '0;
                rpm_reg[c]          <= '0;
                travelled_reg[c]    <= '0;
                edges_reg[c]        <= '0;
                active_reg[c]       <= 1'b0;
                edge_time_reg[c]    <= '0;
            end
        end else begin
            if (state_reg == ST_LOAD) begin
                last_capture_reg[ch_reg] <= cap_reg;
                edge_time_reg[ch_reg]    <= now_reg;
                edges_reg[ch_reg]        <= edges_reg[ch_reg] + DATA_WIDTH'(1);
                if (dir_neg) begin
                    travelled_reg[ch_reg] <= travelled_reg[ch_reg] - step_ext;
                end else if (dir_pos) begin
                    travelled_reg[ch_reg] <= travelled_reg[ch_reg] + step_ext;
                end
            end
            if (state_reg == ST_DIV_SPD && div_status.done) begin
                if (dir_neg) begin
                    speed_reg[ch_reg] <= '0 - speed_mag;
                end else if (dir_pos) begin
                    speed_reg[ch_reg] <= speed_mag;
                end
            end
            if (state_reg == ST_DIV_RPM && div_status.done) begin
                rpm_reg[ch_reg]         <= div_quot;
                edge_period_reg[ch_reg] <= per_reg;
                active_reg[ch_reg]      <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_ch_reg     <= ch_reg;
            out_period_reg <= edge_period_reg[ch_reg];
            out_speed_reg  <= speed_reg[ch_reg];
            out_rpm_reg    <= rpm_reg[ch_reg];
            out_dist_reg   <= travelled_reg[ch_reg];
            out_edges_reg  <= edges_reg[ch_reg];
            out_active_reg <= active_reg[ch_reg];
            out_time_reg   <= edge_time_reg[ch_reg];
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_out_channel  = out_ch_reg;
    assign m_period       = out_period_reg;
    assign m_speed_q8     = signed'(out_speed_reg);
    assign m_rpm_q8       = out_rpm_reg;
    assign m_distance_q16 = signed'(out_dist_reg);
    assign m_edge_count   = out_edges_reg;
    assign m_active       = out_active_reg;
    assign m_edge_time_ms = out_time_reg;

`ifndef SYNTHESIS
    a_accept_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOAD))
        else $error("accepted transaction did not start processing");
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final state");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(out_edges_reg))
        else $error("stalled result overwritten");
`endif

endmodule
